/* design/cwsp_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the shortest path core.
package cwsp_pkg;

  localparam int MAX_ROOMS_DEF = 64;
  localparam int CAP_BITS_DEF  = 16;

  localparam int ROOM_W     = 6;
  localparam int CAP_IN_W   = 16;
  localparam int ANT_W      = 16;
  localparam int RCNT_W     = 7;
  localparam int WT_W       = 17;
  localparam int DIST_W     = 23;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_TUNNEL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_CAP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOM_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANT_COUNT  = 1'b1;

  // Commands from the controller, one per phase of the work.
  typedef struct packed {
    logic accept;
    logic tun_ra;
    logic tun_wa;
    logic tun_rb;
    logic tun_wb;
    logic wt_rd;
    logic wt_ld;
    logic wt_wr;
    logic scan_init;
    logic scan;
    logic take;
    logic rel_rd;
    logic rel;
    logic walk_rd;
    logic walk_wr;
    logic emit_rd;
    logic emit_ld;
    logic nf;
  } cwsp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic tun_ok;
    logic is_run;
    logic div_done;
    logic wt_last;
    logic pipe_done;
    logic cur_v;
    logic cur_is_end;
    logic walk_at_start;
    logic emit_last;
    logic out_free;
  } cwsp_sts_t;

endpackage

/* design/capacity_weighted_shortest_path_core.sv */
// Top level of the capacity-weighted shortest path core: controller plus datapath.
// The core keeps an undirected room graph and finds the cheapest path from room 0 to the
// last room in use, where entering a room costs 1 plus twice the ant count divided by the
// room's capacity plus one whenever that capacity is below the ant count. Input words
// carry a command in in_tuser: add a tunnel, set a capacity, or run a search. Setting a
// capacity writes the store as the word is accepted, while adding a tunnel updates both
// adjacency rows by read-modify-write on a single memory port. A run first computes the
// entry weight of every room in use with a bit-serial divider, one room at a time, then
// runs the search: each selected room costs one linear scan of the distance memory and,
// unless it is the destination, one relaxation sweep over the adjacency row. The path is
// then walked back through the predecessor memory and streamed out, each word held until
// the output register is free. The search is bounded by the memory read port shared by
// the scan and relaxation passes. A run emits one word per room on the path, start first,
// with tlast on the destination, or a single word with tuser (found) low when the
// destination cannot be reached. The tunnel and capacity stores are cleared at reset
// through per-row valid flags, so no clearing pass is needed. Configuration must only be
// written while the core is idle.
module capacity_weighted_shortest_path_core #(
  parameter int MAX_ROOMS = cwsp_pkg::MAX_ROOMS_DEF,
  parameter int CAP_BITS  = cwsp_pkg::CAP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input words.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cwsp_pkg::IN_DATA_W-1:0]  in_tdata,   // room_a[5:0], room_b[11:6], capacity[27:12]
  input  logic [cwsp_pkg::CMD_W-1:0]      in_tuser,   // cmd[1:0]
  // Configuration writes.
  input  logic                            cfg_wr_en,
  input  logic [cwsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwsp_pkg::CFG_DATA_W-1:0] cfg_data,
  // Result words.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cwsp_pkg::OUT_DATA_W-1:0] out_tdata,  // path_room[5:0], edge_weight[22:6],
                                                      // total_distance[45:23]
  output logic                            out_tuser,  // found
  output logic                            out_tlast
);
  import cwsp_pkg::*;

  cwsp_cmd_t cmd;
  cwsp_sts_t sts;

  // The controller sequences each phase; it never touches payload itself.
  cwsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds all stores, the divider and the output register.
  cwsp_dp #(
    .MAX_ROOMS (MAX_ROOMS),
    .CAP_BITS  (CAP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/cwsp_div.sv */
// Restoring divider, one quotient bit per cycle.
module cwsp_div #(
  parameter int DSR_W = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cwsp_pkg::ANT_W-1:0] dividend,
  input  logic [DSR_W-1:0]          divisor,
  output logic                      done,
  output logic [cwsp_pkg::ANT_W-1:0] quotient
);
  import cwsp_pkg::*;

  localparam int CW = $clog2(ANT_W);

  logic [DSR_W-1:0] rem_r, rem_nxt, dsr_r, rem_sh;
  logic [ANT_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r, ge;

  assign rem_sh   = {rem_r[DSR_W-2:0], quo_r[ANT_W-1]};
  assign ge       = (rem_sh >= dsr_r);
  assign rem_nxt  = ge ? (rem_sh - dsr_r) : rem_sh;
  assign quo_nxt  = {quo_r[ANT_W-2:0], ge};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(ANT_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

/* design/cwsp_dp.sv */
// Datapath: graph stores, weight table, search arrays, path stack and output register.
module cwsp_dp #(
  parameter int MAX_ROOMS = cwsp_pkg::MAX_ROOMS_DEF,
  parameter int CAP_BITS  = cwsp_pkg::CAP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cwsp_pkg::cwsp_cmd_t             cmd,
  output cwsp_pkg::cwsp_sts_t             sts,
  input  logic [cwsp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [cwsp_pkg::CMD_W-1:0]      in_tuser,
  input  logic                            cfg_wr_en,
  input  logic [cwsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwsp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cwsp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import cwsp_pkg::*;

  localparam int RW    = $clog2(MAX_ROOMS);
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);
  localparam int CMP_W = ((CAP_BITS > ANT_W) ? CAP_BITS : ANT_W) + 1;
  localparam int STK_W = RW + WT_W;

  // Input word fields.
  logic [ROOM_W-1:0]   f_a, f_b;
  logic [CAP_IN_W-1:0] f_cap;
  logic                a_ok, b_ok;
  assign f_a   = in_tdata[ROOM_W-1:0];
  assign f_b   = in_tdata[2*ROOM_W-1:ROOM_W];
  assign f_cap = in_tdata[2*ROOM_W+CAP_IN_W-1:2*ROOM_W];
  assign a_ok  = ({1'b0, f_a} < (ROOM_W+1)'(MAX_ROOMS));
  assign b_ok  = ({1'b0, f_b} < (ROOM_W+1)'(MAX_ROOMS));

  // Configuration registers.
  logic [RCNT_W-1:0] room_count_r;
  logic [ANT_W-1:0]  ant_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_count_r <= RCNT_W'(MAX_ROOMS);
      ant_count_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROOM_COUNT: room_count_r <= cfg_data[RCNT_W-1:0];
        CFG_ANT_COUNT:  ant_count_r  <= cfg_data[ANT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_rooms;
  logic [RW-1:0]    dest_room;
  always_comb begin
    if (room_count_r < RCNT_W'(2)) n_rooms = CNT_W'(2);
    else if (room_count_r > RCNT_W'(MAX_ROOMS)) n_rooms = CNT_W'(MAX_ROOMS);
    else n_rooms = CNT_W'(room_count_r);
  end
  assign dest_room = RW'(n_rooms - 1'b1);

  // Control registers.
  logic [RW-1:0]        a_r, b_r, cur_r, jd_r, r_r;
  logic [CNT_W-1:0]     j_r, sp_r;
  logic                 vd_r, cur_v_r, out_valid_r;
  logic [MAX_ROOMS-1:0] reached_r, visited_r, adj_valid_r, cap_valid_r;
  logic [DIST_W-1:0]    best_d_r;
  logic [WT_W-1:0]      prev_w_r;
  logic                 penalty_r;

  // Memories and registered read data.
  logic [MAX_ROOMS-1:0] adj_mem [MAX_ROOMS];
  logic [CAP_BITS-1:0]  cap_mem [MAX_ROOMS];
  logic [WT_W-1:0]      wt_mem  [MAX_ROOMS];
  logic [DIST_W-1:0]    dist_mem[MAX_ROOMS];
  logic [RW-1:0]        pred_mem[MAX_ROOMS];
  logic [STK_W-1:0]     stk_mem [MAX_ROOMS];

  logic [MAX_ROOMS-1:0] adj_q;
  logic                 adj_vq, cap_vq;
  logic [CAP_BITS-1:0]  cap_q;
  logic [WT_W-1:0]      wt_q;
  logic [DIST_W-1:0]    dist_q;
  logic [RW-1:0]        pred_q;
  logic [STK_W-1:0]     stk_q;

  logic [MAX_ROOMS-1:0] adj_row;
  logic [RW-1:0]        adj_ra, rd_idx, j_idx;
  logic                 adj_rd, issue;
  assign adj_row = adj_q & {MAX_ROOMS{adj_vq}};
  assign adj_rd  = cmd.tun_ra | cmd.tun_rb | cmd.rel_rd;
  assign adj_ra  = cmd.tun_ra ? a_r : (cmd.tun_rb ? b_r : cur_r);
  assign j_idx   = j_r[RW-1:0];
  assign rd_idx  = cmd.walk_rd ? r_r : j_idx;
  assign issue   = (cmd.scan | cmd.rel) & (j_r < n_rooms);

  always_ff @(posedge clk) begin
    if (adj_rd) begin
      adj_q  <= adj_mem[adj_ra];
      adj_vq <= adj_valid_r[adj_ra];
    end
    if (cmd.tun_wa) adj_mem[a_r] <= adj_row | (MAX_ROOMS'(1) << b_r);
    if (cmd.tun_wb) adj_mem[b_r] <= adj_row | (MAX_ROOMS'(1) << a_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.wt_rd) begin
      cap_q  <= cap_mem[j_idx];
      cap_vq <= cap_valid_r[j_idx];
    end
    if (cmd.accept && in_tuser == CMD_SET_CAP && a_ok)
      cap_mem[f_a[RW-1:0]] <= CAP_BITS'(f_cap);
  end

  // Penalty weight: 1 + 2 * (ants / (capacity + 1)) when capacity is short.
  logic [CMP_W-1:0]  cap_ext, ant_ext;
  logic [ANT_W-1:0]  quo;
  logic [WT_W-1:0]   wt_new;
  logic              div_done;
  assign cap_ext = CMP_W'(cap_q & {CAP_BITS{cap_vq}});
  assign ant_ext = CMP_W'(ant_count_r);
  assign wt_new  = penalty_r ? WT_W'({quo, 1'b1}) : WT_W'(1);

  cwsp_div #(.DSR_W(CMP_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.wt_ld),
    .dividend (ant_count_r),
    .divisor  (cap_ext + CMP_W'(1)),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.wt_ld) penalty_r <= (cap_ext < ant_ext);
    if (cmd.wt_wr) wt_mem[j_idx] <= wt_new;
  end

  // Search arrays.
  logic [DIST_W:0]   nd_sum;
  logic [DIST_W-1:0] nd;
  logic              rel_hit, rel_upd, scan_hit;
  assign nd_sum   = {1'b0, best_d_r} + (DIST_W+1)'(wt_q);
  assign nd       = nd_sum[DIST_W-1:0];
  assign rel_hit  = cmd.rel & vd_r & adj_row[jd_r] & ~visited_r[jd_r];
  assign rel_upd  = rel_hit & (~reached_r[jd_r] | (nd < dist_q));
  assign scan_hit = cmd.scan & vd_r & reached_r[jd_r] & ~visited_r[jd_r] &
                    (~cur_v_r | (dist_q < best_d_r));

  always_ff @(posedge clk) begin
    if (issue || cmd.walk_rd) begin
      dist_q <= dist_mem[rd_idx];
      wt_q   <= wt_mem[rd_idx];
      pred_q <= pred_mem[rd_idx];
    end
    if (cmd.accept && in_tuser == CMD_RUN) dist_mem[RW'(0)] <= '0;
    else if (rel_upd) dist_mem[jd_r] <= nd;
    if (rel_upd) pred_mem[jd_r] <= cur_r;
    if (cmd.walk_wr) stk_mem[sp_r[RW-1:0]] <= {r_r, prev_w_r};
    if (cmd.emit_rd) stk_q <= stk_mem[RW'(sp_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_valid_r <= '0;
      cap_valid_r <= '0;
      reached_r   <= '0;
      visited_r   <= '0;
      j_r         <= '0;
      sp_r        <= '0;
      vd_r        <= 1'b0;
      cur_v_r     <= 1'b0;
    end else begin
      if (cmd.tun_wa) adj_valid_r[a_r] <= 1'b1;
      if (cmd.tun_wb) adj_valid_r[b_r] <= 1'b1;
      if (cmd.accept && in_tuser == CMD_SET_CAP && a_ok) cap_valid_r[f_a[RW-1:0]] <= 1'b1;
      if (cmd.accept && in_tuser == CMD_RUN) begin
        reached_r <= MAX_ROOMS'(1);
        visited_r <= '0;
        j_r       <= '0;
      end
      if (cmd.wt_wr) j_r <= j_r + 1'b1;
      if (cmd.scan_init || cmd.rel_rd) begin
        j_r  <= '0;
        vd_r <= 1'b0;
      end
      if (cmd.scan_init) cur_v_r <= 1'b0;
      if (cmd.scan || cmd.rel) begin
        vd_r <= issue;
        if (issue) j_r <= j_r + 1'b1;
      end
      if (scan_hit) cur_v_r <= 1'b1;
      if (rel_upd) reached_r[jd_r] <= 1'b1;
      if (cmd.take) begin
        visited_r[cur_r] <= 1'b1;
        sp_r             <= '0;
      end
      if (cmd.walk_wr) sp_r <= sp_r + 1'b1;
      if (cmd.emit_rd) sp_r <= sp_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_r <= f_a[RW-1:0];
      b_r <= f_b[RW-1:0];
    end
    if (issue) jd_r <= j_idx;
    if (scan_hit) begin
      cur_r    <= jd_r;
      best_d_r <= dist_q;
    end
    if (cmd.take) begin
      r_r      <= cur_r;
      prev_w_r <= '0;
    end
    if (cmd.walk_wr) begin
      prev_w_r <= wt_q;
      if (r_r != '0) r_r <= pred_q;
    end
  end

  // Output register.
  logic                out_free;
  logic [ROOM_W-1:0]   o_room_r;
  logic [WT_W-1:0]     o_wt_r;
  logic [DIST_W-1:0]   o_dist_r;
  logic                o_found_r, o_last_r;
  assign out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.emit_ld || cmd.nf) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld && out_free) begin
      o_room_r  <= ROOM_W'(stk_q[STK_W-1:WT_W]);
      o_wt_r    <= stk_q[WT_W-1:0];
      o_dist_r  <= best_d_r;
      o_found_r <= 1'b1;
      o_last_r  <= (sp_r == '0);
    end else if (cmd.nf && out_free) begin
      o_room_r  <= '0;
      o_wt_r    <= '0;
      o_dist_r  <= '0;
      o_found_r <= 1'b0;
      o_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({o_dist_r, o_wt_r, o_room_r});
  assign out_tuser  = o_found_r;
  assign out_tlast  = o_last_r;

  assign sts.tun_ok        = (in_tuser == CMD_TUNNEL) & a_ok & b_ok;
  assign sts.is_run        = (in_tuser == CMD_RUN);
  assign sts.div_done      = div_done;
  assign sts.wt_last       = (j_r == n_rooms - 1'b1);
  assign sts.pipe_done     = (j_r >= n_rooms) & ~vd_r;
  assign sts.cur_v         = cur_v_r;
  assign sts.cur_is_end    = (cur_r == dest_room);
  assign sts.walk_at_start = (r_r == '0);
  assign sts.emit_last     = (sp_r == '0);
  assign sts.out_free      = out_free;

`ifndef ASSERT_OFF
  a_visited_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (visited_r & ~reached_r) == '0)
    else $error("visited room that was never reached");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= n_rooms)
    else $error("path stack beyond room count");
  a_take_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> visited_r[$past(cur_r)])
    else $error("selected room not marked visited");
  a_rel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rel_upd |-> (CNT_W'(jd_r) < n_rooms))
    else $error("relaxation beyond rooms in use");
`endif

endmodule

/* design/cwsp_ctrl.sv */
// Controller state machine sequencing loads, weight setup, search, path walk and output.
module cwsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  cwsp_pkg::cwsp_sts_t sts,
  output cwsp_pkg::cwsp_cmd_t cmd
);
  import cwsp_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_TUN_RA  = 17'h00002,
    S_TUN_WA  = 17'h00004,
    S_TUN_RB  = 17'h00008,
    S_TUN_WB  = 17'h00010,
    S_WT_RD   = 17'h00020,
    S_WT_LD   = 17'h00040,
    S_WT_DIV  = 17'h00080,
    S_WT_WR   = 17'h00100,
    S_SCAN    = 17'h00200,
    S_REL_RD  = 17'h00400,
    S_REL     = 17'h00800,
    S_WALK_RD = 17'h01000,
    S_WALK_WR = 17'h02000,
    S_EMIT_RD = 17'h04000,
    S_EMIT_LD = 17'h08000,
    S_NF      = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.tun_ok) state_nxt = S_TUN_RA;
          else if (sts.is_run) state_nxt = S_WT_RD;
        end
      end
      S_TUN_RA: begin
        cmd.tun_ra = 1'b1;
        state_nxt  = S_TUN_WA;
      end
      S_TUN_WA: begin
        cmd.tun_wa = 1'b1;
        state_nxt  = S_TUN_RB;
      end
      S_TUN_RB: begin
        cmd.tun_rb = 1'b1;
        state_nxt  = S_TUN_WB;
      end
      S_TUN_WB: begin
        cmd.tun_wb = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_WT_RD: begin
        cmd.wt_rd = 1'b1;
        state_nxt = S_WT_LD;
      end
      S_WT_LD: begin
        cmd.wt_ld = 1'b1;
        state_nxt = S_WT_DIV;
      end
      S_WT_DIV: begin
        if (sts.div_done) state_nxt = S_WT_WR;
      end
      S_WT_WR: begin
        cmd.wt_wr = 1'b1;
        if (sts.wt_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_WT_RD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.pipe_done) begin
          if (!sts.cur_v) begin
            state_nxt = S_NF;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = sts.cur_is_end ? S_WALK_RD : S_REL_RD;
          end
        end
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_REL;
      end
      S_REL: begin
        cmd.rel = 1'b1;
        if (sts.pipe_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = sts.walk_at_start ? S_EMIT_RD : S_WALK_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (sts.out_free) state_nxt = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
      S_NF: begin
        cmd.nf = 1'b1;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
